/* rtl/chdq_pkg.sv */
// chdq_pkg: shared types and constants of the character deque engine
// operation and status codes, controller states, command and status structs
// no dependencies
package chdq_pkg;

	// default number of ring entries
	localparam int DEPTH_DEF = 32;

	// stream payload widths
	localparam int S_DATA_W = 16;
	localparam int M_DATA_W = 8;
	localparam int M_USER_W = 2;

	// operation codes carried in the input item
	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_DUMP       = 3'd4
	} op_t;

	// result status codes
	typedef enum logic [1:0] {
		STAT_DATA  = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	// controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_STATUS,
		S_WAIT,
		S_DUMP
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic    wr_front;
		logic    wr_back;
		logic    pop_front;
		logic    pop_back;
		logic    idx_clear;
		logic    dump_rd;
		logic    rd_take;
		logic    stat_load;
		status_t stat_code;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic empty;
		logic full;
		logic rd_valid;
		logic rd_last;
		logic out_free;
		logic dump_more;
	} sts_t;

endpackage

/* rtl/chdq_dpath.sv */
// chdq_dpath: ring store, front and count registers, read stage and output register
// driven by commands from chdq_ctrl
// depends on chdq_pkg
module chdq_dpath #(
	parameter int DEPTH = chdq_pkg::DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  chdq_pkg::cmd_t   cmd,
	input  logic [7:0]       char_in,
	output chdq_pkg::sts_t   sts,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       out_char,
	output chdq_pkg::status_t out_status,
	output logic             out_last
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	// ring position: base plus offset, folded once
	function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] base,
		input logic [CW-1:0] off);
		logic [CW:0] sum;
		sum = {{(CW + 1 - AW){1'b0}}, base} + {1'b0, off};
		if (sum >= (CW + 1)'(DEPTH)) begin
			sum = sum - (CW + 1)'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	logic [7:0]    mem_q [DEPTH];
	logic [AW-1:0] front_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic          rd_valid_q;
	logic          rd_last_q;
	logic [7:0]    rd_data_q;
	logic          out_valid_q;
	logic [7:0]    out_char_q;
	chdq_pkg::status_t out_status_q;
	logic          out_last_q;

	logic [AW-1:0] front_dec;
	logic [AW-1:0] front_inc;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic [CW-1:0] idx_nxt;
	logic          wr_en;
	logic          rd_en;
	logic          pop;
	logic          out_free;

	// address arithmetic
	always_comb begin
		front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - 1'b1;
		front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + 1'b1;
		idx_nxt   = idx_q + CW'(1);
		pop       = cmd.pop_front | cmd.pop_back;
		wr_en     = cmd.wr_front | cmd.wr_back;
		rd_en     = pop | cmd.dump_rd;
		wr_addr   = cmd.wr_front ? front_dec : ring_pos(front_q, count_q);
		if (cmd.pop_front) begin
			rd_addr = front_q;
		end else if (cmd.pop_back) begin
			rd_addr = ring_pos(front_q, count_q - CW'(1));
		end else begin
			rd_addr = ring_pos(front_q, idx_q);
		end
		out_free = !out_valid_q || out_ready;
	end

	// ring store, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= char_in;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
			rd_last_q <= pop || (idx_nxt == count_q);
		end
	end

	// front, count and dump index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			if (cmd.wr_front) begin
				front_q <= front_dec;
			end else if (cmd.pop_front) begin
				front_q <= front_inc;
			end
			if (wr_en) begin
				count_q <= count_q + CW'(1);
			end else if (pop) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.idx_clear) begin
				idx_q <= '0;
			end else if (cmd.dump_rd) begin
				idx_q <= idx_nxt;
			end
		end
	end

	// read stage valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_q <= 1'b0;
		end else if (rd_en) begin
			rd_valid_q <= 1'b1;
		end else if (cmd.rd_take) begin
			rd_valid_q <= 1'b0;
		end
	end

	// output register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.stat_load || cmd.rd_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.stat_load) begin
			out_char_q   <= '0;
			out_status_q <= cmd.stat_code;
			out_last_q   <= 1'b1;
		end else if (cmd.rd_take) begin
			out_char_q   <= rd_data_q;
			out_status_q <= chdq_pkg::STAT_DATA;
			out_last_q   <= rd_last_q;
		end
	end

	// status back to controller
	always_comb begin
		sts.empty     = (count_q == '0);
		sts.full      = (count_q == CW'(DEPTH));
		sts.rd_valid  = rd_valid_q;
		sts.rd_last   = rd_last_q;
		sts.out_free  = out_free;
		sts.dump_more = (idx_q < count_q);
	end

	assign out_valid  = out_valid_q;
	assign out_char   = out_char_q;
	assign out_status = out_status_q;
	assign out_last   = out_last_q;

	// a waiting result is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !(cmd.stat_load || cmd.rd_take))
		else $error("output register overwritten while stalled");

	// only a valid read stage is moved to the output
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_take |-> rd_valid_q)
		else $error("read stage taken while empty");

	// fill count and front pointer stay within the ring
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q <= CW'(DEPTH)) && (front_q <= AW'(DEPTH - 1)))
		else $error("ring pointer out of range");

	// no push into a full ring and no pop from an empty one
	assert property (@(posedge clk) disable iff (!arst_n)
		!((cmd.wr_front || cmd.wr_back) && (count_q == CW'(DEPTH)))
		&& !((cmd.pop_front || cmd.pop_back) && (count_q == '0)))
		else $error("ring overflow or underflow");

endmodule

/* rtl/chdq_ctrl.sv */
// chdq_ctrl: state machine that decodes operations and sequences pops and dumps
// issues commands to chdq_dpath and reads its status
// depends on chdq_pkg
module chdq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [2:0]     op_code,
	input  chdq_pkg::sts_t sts,
	output chdq_pkg::cmd_t cmd
);

	chdq_pkg::state_t  state_q;
	chdq_pkg::state_t  state_nxt;
	chdq_pkg::status_t stat_q;
	chdq_pkg::status_t stat_nxt;
	chdq_pkg::op_t     op;
	logic              take;
	logic              stat_set;

	assign op   = chdq_pkg::op_t'(op_code);
	assign take = sts.rd_valid && sts.out_free;

	// next state
	always_comb begin
		state_nxt = state_q;
		stat_nxt  = stat_q;
		stat_set  = 1'b0;
		unique case (state_q)
			chdq_pkg::S_IDLE: begin
				if (in_valid) begin
					unique case (op)
						chdq_pkg::OP_PUSH_FRONT, chdq_pkg::OP_PUSH_BACK: begin
							if (sts.full) begin
								stat_set = 1'b1;
								stat_nxt = chdq_pkg::STAT_FULL;
							end
						end
						chdq_pkg::OP_POP_FRONT, chdq_pkg::OP_POP_BACK: begin
							if (sts.empty) begin
								stat_set = 1'b1;
								stat_nxt = chdq_pkg::STAT_EMPTY;
							end else begin
								state_nxt = chdq_pkg::S_WAIT;
							end
						end
						chdq_pkg::OP_DUMP: begin
							if (sts.empty) begin
								stat_set = 1'b1;
								stat_nxt = chdq_pkg::STAT_EMPTY;
							end else begin
								state_nxt = chdq_pkg::S_DUMP;
							end
						end
						default: begin
						end
					endcase
					if (stat_set) begin
						state_nxt = chdq_pkg::S_STATUS;
					end
				end
			end
			chdq_pkg::S_STATUS: begin
				if (sts.out_free) begin
					state_nxt = chdq_pkg::S_IDLE;
				end
			end
			chdq_pkg::S_WAIT: begin
				if (take) begin
					state_nxt = chdq_pkg::S_IDLE;
				end
			end
			chdq_pkg::S_DUMP: begin
				if (take && sts.rd_last) begin
					state_nxt = chdq_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = chdq_pkg::S_IDLE;
			end
		endcase
	end

	// state and pending status code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= chdq_pkg::S_IDLE;
			stat_q  <= chdq_pkg::STAT_DATA;
		end else begin
			state_q <= state_nxt;
			stat_q  <= stat_nxt;
		end
	end

	// command outputs
	always_comb begin
		in_ready      = 1'b0;
		cmd           = '0;
		cmd.stat_code = stat_q;
		unique case (state_q)
			chdq_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (op)
						chdq_pkg::OP_PUSH_FRONT: cmd.wr_front  = !sts.full;
						chdq_pkg::OP_PUSH_BACK:  cmd.wr_back   = !sts.full;
						chdq_pkg::OP_POP_FRONT:  cmd.pop_front = !sts.empty;
						chdq_pkg::OP_POP_BACK:   cmd.pop_back  = !sts.empty;
						chdq_pkg::OP_DUMP:       cmd.idx_clear = 1'b1;
						default: begin
						end
					endcase
				end
			end
			chdq_pkg::S_STATUS: begin
				cmd.stat_load = sts.out_free;
			end
			chdq_pkg::S_WAIT: begin
				cmd.rd_take = take;
			end
			chdq_pkg::S_DUMP: begin
				cmd.rd_take = take;
				cmd.dump_rd = sts.dump_more && (!sts.rd_valid || take);
			end
			default: begin
			end
		endcase
	end

	// input is taken only in idle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (state_q == chdq_pkg::S_IDLE))
		else $error("input ready outside idle");

	// a dump read is only issued while the read stage can take it
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dump_rd |-> (!sts.rd_valid || cmd.rd_take))
		else $error("dump read would overrun read stage");

	// a pop always leads to the wait state
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pop_front || cmd.pop_back) |=> (state_q == chdq_pkg::S_WAIT))
		else $error("pop not followed by wait");

endmodule

/* rtl/char_deque_engine.sv */
// char_deque_engine: double-ended byte queue in a ring of DEPTH entries
// a successful push gives no result; a pop or a rejected push/pop loads its result into the output
// register, a pop via the read stage and a rejection via the status state, then input reopens
// dump of N bytes: each byte goes via the read stage to the output register, one per cycle
// output stalls stretch pops and dumps; the next item enters while a result waits
// reset: asynchronous, clears pointers, count and handshake state; store contents stay undefined
module char_deque_engine #(
	parameter int DEPTH = chdq_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [chdq_pkg::S_DATA_W-1:0] s_tdata,  // operation[2:0], char_in[10:3], zero
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [chdq_pkg::M_DATA_W-1:0] m_tdata,  // char_out[7:0]
	output logic [chdq_pkg::M_USER_W-1:0] m_tuser,  // status[1:0]
	output logic                          m_tlast   // last_of_run
);

	chdq_pkg::cmd_t    cmd;
	chdq_pkg::sts_t    sts;
	chdq_pkg::status_t out_status;

	// operation decode and sequencing
	chdq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.op_code  (s_tdata[2:0]),
		.sts      (sts),
		.cmd      (cmd)
	);

	// ring store and output register
	chdq_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.char_in    (s_tdata[10:3]),
		.sts        (sts),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_char   (m_tdata),
		.out_status (out_status),
		.out_last   (m_tlast)
	);

	assign m_tuser = out_status;

endmodule
